FILE: design/jsu_pkg.sv
package jsu_pkg;

  localparam logic [15:0] HIGH_FIRST    = 16'hD800;
  localparam logic [15:0] HIGH_LAST     = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST     = 16'hDC00;
  localparam logic [15:0] LOW_LAST      = 16'hDFFF;
  localparam logic [15:0] CONTROL_LIMIT = 16'h0020;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_B      = 16'h0062;
  localparam logic [15:0] CH_F      = 16'h0066;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CH_U      = 16'h0075;

  localparam logic [15:0] CC_BS = 16'h0008;
  localparam logic [15:0] CC_FF = 16'h000C;
  localparam logic [15:0] CC_LF = 16'h000A;
  localparam logic [15:0] CC_CR = 16'h000D;
  localparam logic [15:0] CC_HT = 16'h0009;

  localparam int unsigned RESULT_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_PLAIN    = 3'd0,
    PH_ESC      = 3'd1,
    PH_HEX1     = 3'd2,
    PH_WANT_BS  = 3'd3,
    PH_WANT_U   = 3'd4,
    PH_HEX2     = 3'd5,
    PH_RAW_HIGH = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_CLOSED        = 4'd1,
    ST_CONTROL       = 4'd2,
    ST_INCOMPLETE    = 4'd3,
    ST_UNKNOWN       = 4'd4,
    ST_SHORT_HEX     = 4'd5,
    ST_BAD_HEX       = 4'd6,
    ST_NO_LOW        = 4'd7,
    ST_BAD_LOW       = 4'd8,
    ST_LONE_LOW_ESC  = 4'd9,
    ST_LONE_RAW_HIGH = 4'd10,
    ST_LONE_RAW_LOW  = 4'd11,
    ST_UNTERMINATED  = 4'd12
  } status_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        at_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        has_unit;
    status_t     status;
    logic        last;
  } out_item_t;

  function automatic logic is_high(input logic [15:0] u);
    return (u >= HIGH_FIRST) && (u <= HIGH_LAST);
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return (u >= LOW_FIRST) && (u <= LOW_LAST);
  endfunction

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_value(input logic [15:0] u);
    logic [4:0] v;
    v = 5'h10;
    if (u >= 16'h0030 && u <= 16'h0039) v = {1'b0, u[3:0]};
    else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046))
      v = {1'b0, u[3:0] + 4'd9};
    return v;
  endfunction

  // Bit 16 set: a known simple escape, low bits hold the decoded unit.
  function automatic logic [16:0] esc_map(input logic [15:0] u);
    logic [16:0] m;
    m = '0;
    case (u)
      CH_QUOTE:  m = {1'b1, CH_QUOTE};
      CH_BSLASH: m = {1'b1, CH_BSLASH};
      CH_SLASH:  m = {1'b1, CH_SLASH};
      CH_B:      m = {1'b1, CC_BS};
      CH_F:      m = {1'b1, CC_FF};
      CH_N:      m = {1'b1, CC_LF};
      CH_R:      m = {1'b1, CC_CR};
      CH_T:      m = {1'b1, CC_HT};
      default:   m = '0;
    endcase
    return m;
  endfunction

  function automatic out_item_t mk_unit(input logic [15:0] u, input logic last);
    out_item_t r;
    r.out_unit = u;
    r.has_unit = 1'b1;
    r.status   = ST_OK;
    r.last     = last;
    return r;
  endfunction

  function automatic out_item_t mk_finish(input status_t st);
    out_item_t r;
    r.out_unit = '0;
    r.has_unit = 1'b0;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

endpackage

FILE: design/json_string_unescape_top.sv
// JSON string body unescaper over UTF-16 code units. Feed the units that
// follow the opening quote, one per beat; at_end marks the end of the text.
// Each beat yields zero result beats (a unit absorbed into an escape or a held
// high surrogate), one (a decoded unit, a close, or an error) or two (a
// surrogate pair, the first with last low). Status 1 to 12 closes the string
// and returns the block to plain text, so the next beat starts a new body.
// Rate: one input beat per clock while the result buffer has room; results are
// registered in a two-entry result buffer that drains one beat per cycle while
// result_ready is high, so a surrogate pair holds off the input until its head
// beat drains, even when the consumer never stalls.
module json_string_unescape_top
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  // Decoder state
  phase_t      phase, phase_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] quad_value, quad_value_next;
  logic [15:0] held_high, held_high_next;
  logic        bad_digit_seen, bad_digit_seen_next;

  // Result buffer: slot 0 is the head
  out_item_t   slot [RESULT_DEPTH];
  out_item_t   slot_next [RESULT_DEPTH];
  logic [1:0]  count, count_next;

  logic        accept, pop;
  logic [1:0]  remain;

  // Per-beat decode terms
  logic [15:0] u;
  logic        at_end;
  logic [4:0]  hexd;
  logic        bad_now;
  logic [15:0] quad_shift;
  logic        fourth;
  logic [16:0] esc;

  logic [1:0]  res_n;
  out_item_t   res0, res1;

  assign u          = item.code_unit;
  assign at_end     = item.at_end;
  assign hexd       = hex_value(u);
  assign bad_now    = hexd[4];
  assign quad_shift = {quad_value[11:0], bad_now ? 4'd0 : hexd[3:0]};
  assign fourth     = (digit_count == 2'd3);
  assign esc        = esc_map(u);

  // Take a beat whenever the buffer can hold two results after this cycle's drain.
  assign pop          = result_valid && result_ready;
  assign item_ready   = (count == 2'd0) || ((count == 2'd1) && result_ready);
  assign accept       = item_valid && item_ready;
  assign result_valid = (count != 2'd0);
  assign result       = slot[0];
  assign remain       = count - {1'b0, pop};

  // Next state of the decoder
  always_comb begin
    logic clr;
    clr                 = 1'b0;
    phase_next          = phase;
    digit_count_next    = digit_count;
    quad_value_next     = quad_value;
    held_high_next      = held_high;
    bad_digit_seen_next = bad_digit_seen;
    unique case (phase)
      PH_ESC: begin
        if (at_end) begin
          clr = 1'b1;
        end else if (u == CH_U) begin
          phase_next          = PH_HEX1;
          digit_count_next    = 2'd0;
          quad_value_next     = '0;
          bad_digit_seen_next = 1'b0;
        end else if (esc[16]) begin
          phase_next = PH_PLAIN;
        end else begin
          clr = 1'b1;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (at_end) begin
          clr = 1'b1;
        end else if (!fourth) begin
          quad_value_next     = quad_shift;
          digit_count_next    = digit_count + 2'd1;
          bad_digit_seen_next = bad_digit_seen | bad_now;
        end else if (phase == PH_HEX1 && !(bad_digit_seen | bad_now)
                     && is_high(quad_shift)) begin
          held_high_next   = quad_shift;
          quad_value_next  = quad_shift;
          digit_count_next = 2'd0;
          phase_next       = PH_WANT_BS;
        end else if (phase == PH_HEX1 && !(bad_digit_seen | bad_now)
                     && !is_low(quad_shift)) begin
          quad_value_next  = quad_shift;
          digit_count_next = 2'd0;
          phase_next       = PH_PLAIN;
        end else begin
          // error, lone low escape or a completed pair
          clr = 1'b1;
        end
      end
      PH_WANT_BS: begin
        if (at_end || u != CH_BSLASH) clr = 1'b1;
        else phase_next = PH_WANT_U;
      end
      PH_WANT_U: begin
        if (at_end || u != CH_U) begin
          clr = 1'b1;
        end else begin
          phase_next          = PH_HEX2;
          digit_count_next    = 2'd0;
          quad_value_next     = '0;
          bad_digit_seen_next = 1'b0;
        end
      end
      PH_RAW_HIGH: begin
        clr = 1'b1;
      end
      default: begin
        phase_next = PH_PLAIN;
        if (at_end || u == CH_QUOTE || u < CONTROL_LIMIT) begin
          clr = 1'b1;
        end else if (u == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (is_high(u)) begin
          held_high_next = u;
          phase_next     = PH_RAW_HIGH;
        end else if (is_low(u)) begin
          clr = 1'b1;
        end
      end
    endcase
    if (clr) begin
      phase_next          = PH_PLAIN;
      digit_count_next    = '0;
      quad_value_next     = '0;
      held_high_next      = '0;
      bad_digit_seen_next = 1'b0;
    end
  end

  // Result beats caused by the current input beat
  always_comb begin
    res_n = 2'd0;
    res0  = mk_finish(ST_OK);
    res1  = mk_finish(ST_OK);
    unique case (phase)
      PH_ESC: begin
        if (at_end) begin
          res_n = 2'd1; res0 = mk_finish(ST_INCOMPLETE);
        end else if (u == CH_U) begin
          res_n = 2'd0;
        end else if (esc[16]) begin
          res_n = 2'd1; res0 = mk_unit(esc[15:0], 1'b1);
        end else begin
          res_n = 2'd1; res0 = mk_finish(ST_UNKNOWN);
        end
      end
      PH_HEX1: begin
        if (at_end) begin
          res_n = 2'd1; res0 = mk_finish(ST_SHORT_HEX);
        end else if (!fourth || (!(bad_digit_seen | bad_now) && is_high(quad_shift))) begin
          res_n = 2'd0;
        end else if (bad_digit_seen | bad_now) begin
          res_n = 2'd1; res0 = mk_finish(ST_BAD_HEX);
        end else if (is_low(quad_shift)) begin
          res_n = 2'd1; res0 = mk_finish(ST_LONE_LOW_ESC);
        end else begin
          res_n = 2'd1; res0 = mk_unit(quad_shift, 1'b1);
        end
      end
      PH_WANT_BS: begin
        if (at_end || u != CH_BSLASH) begin
          res_n = 2'd1; res0 = mk_finish(ST_NO_LOW);
        end
      end
      PH_WANT_U: begin
        if (at_end || u != CH_U) begin
          res_n = 2'd1; res0 = mk_finish(ST_NO_LOW);
        end
      end
      PH_HEX2: begin
        if (at_end) begin
          res_n = 2'd1; res0 = mk_finish(ST_SHORT_HEX);
        end else if (!fourth) begin
          res_n = 2'd0;
        end else if (bad_digit_seen | bad_now) begin
          res_n = 2'd1; res0 = mk_finish(ST_BAD_HEX);
        end else if (!is_low(quad_shift)) begin
          res_n = 2'd1; res0 = mk_finish(ST_BAD_LOW);
        end else begin
          res_n = 2'd2;
          res0  = mk_unit(held_high, 1'b0);
          res1  = mk_unit(quad_shift, 1'b1);
        end
      end
      PH_RAW_HIGH: begin
        if (at_end || !is_low(u)) begin
          res_n = 2'd1; res0 = mk_finish(ST_LONE_RAW_HIGH);
        end else begin
          res_n = 2'd2;
          res0  = mk_unit(held_high, 1'b0);
          res1  = mk_unit(u, 1'b1);
        end
      end
      default: begin
        if (at_end) begin
          res_n = 2'd1; res0 = mk_finish(ST_UNTERMINATED);
        end else if (u == CH_QUOTE) begin
          res_n = 2'd1; res0 = mk_finish(ST_CLOSED);
        end else if (u < CONTROL_LIMIT) begin
          res_n = 2'd1; res0 = mk_finish(ST_CONTROL);
        end else if (u == CH_BSLASH || is_high(u)) begin
          res_n = 2'd0;
        end else if (is_low(u)) begin
          res_n = 2'd1; res0 = mk_finish(ST_LONE_RAW_LOW);
        end else begin
          res_n = 2'd1; res0 = mk_unit(u, 1'b1);
        end
      end
    endcase
  end

  // Buffer update: drain the head, then append new results behind what remains.
  always_comb begin
    slot_next[0] = pop ? slot[1] : slot[0];
    slot_next[1] = slot[1];
    count_next   = remain;
    if (accept) begin
      if (remain == 2'd0) begin
        slot_next[0] = res0;
        slot_next[1] = res1;
      end else begin
        slot_next[1] = res0;
      end
      count_next = remain + res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_PLAIN;
      digit_count    <= '0;
      quad_value     <= '0;
      held_high      <= '0;
      bad_digit_seen <= 1'b0;
      count          <= '0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        digit_count    <= digit_count_next;
        quad_value     <= quad_value_next;
        held_high      <= held_high_next;
        bad_digit_seen <= bad_digit_seen_next;
      end
      count <= count_next;
    end
  end

  // Payload slots hold no reset
  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

  // The buffer never holds more than two beats.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overfilled");

  // The first half of a pair is only ever at the head of a full buffer.
  a_pair_whole: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (count == 2'd2 && slot[1].last))
    else $error("surrogate pair split in result buffer");

  // A beat without a unit always carries a closing or error status.
  a_nounit_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.has_unit) |-> (result.status != ST_OK))
    else $error("empty result beat with ok status");

  // A full buffer accepts nothing.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !item_ready)
    else $error("input taken while result buffer full");

endmodule
